### rtl/dls_pkg.sv
`default_nettype none

package dls_pkg;

  // Default geometry of the stack.
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ITEM_WIDTH_DEF = 32;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = $clog2(DEPTH_DEF + 1);

  // Operation codes carried in the mode field. Code 3 is unused.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_TOP  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               was_present;
    logic [VALUE_W-1:0] top_value;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

`default_nettype wire

### rtl/dls_cell.sv
`default_nettype none

module dls_cell
  import dls_pkg::*;
#(
  parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire shift_ctl_t            ctl,
  input  wire logic [ITEM_WIDTH-1:0] up_data,
  input  wire logic [ITEM_WIDTH-1:0] dn_data,
  input  wire logic [ITEM_WIDTH-1:0] cmp_value,
  input  wire logic                  occupied,
  output logic      [ITEM_WIDTH-1:0] data,
  output logic                       hit
);

  logic [ITEM_WIDTH-1:0] data_r;
  logic [ITEM_WIDTH-1:0] data_nxt;

  // A push moves every entry one place away from the top, a pop one place toward it.
  always_comb begin
    if (ctl.push) begin
      data_nxt = up_data;
    end else if (ctl.pop) begin
      data_nxt = dn_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = occupied && (data_r == cmp_value);

endmodule

`default_nettype wire

### rtl/dedup_lifo_stack.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_data   (in_item_t: mode, item_value)
// out_      output     out_valid/out_stall out_data (out_item_t: status .. entry_count)
//
// The duplicate search is done by one comparator per cell in parallel, and the
// result is registered in the output stage.
// A new transaction is taken every cycle while the output stage is free or drains.
// Reset clears the entry count and the output valid; entry storage is not cleared.
// While out_stall holds a waiting result, in_stall is raised and the stack holds still.

module dedup_lifo_stack
  import dls_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Stack occupancy. Cell 0 holds the top of the stack.
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;

  logic                  accept;
  logic [ITEM_WIDTH-1:0] push_value;
  logic [ITEM_WIDTH-1:0] cell_q [DEPTH];
  logic [DEPTH-1:0]      hit;
  logic                  found;
  logic                  full;
  logic                  empty;
  shift_ctl_t            ctl;

  // The stage is blocked only when its registered result cannot leave this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Only the low ITEM_WIDTH bits of the pushed value are stored and compared.
  assign push_value = ITEM_WIDTH'(in_data.item_value);

  // The chain of cells. Each cell compares its entry against the incoming value
  // and takes its neighbor's entry whenever the stack shifts; on a push cell 0 takes the pushed value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] up_d;
    logic [ITEM_WIDTH-1:0] dn_d;
    logic                  occ;

    if (i == 0) begin : g_first
      assign up_d = push_value;
    end else begin : g_mid_up
      assign up_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_d = cell_q[i];
    end else begin : g_mid_dn
      assign dn_d = cell_q[i+1];
    end

    // Only cells that currently hold an entry take part in the duplicate search.
    assign occ = (CNT_W'(i) < count_r);

    dls_cell #(
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .up_data   (up_d),
      .dn_data   (dn_d),
      .cmp_value (push_value),
      .occupied  (occ),
      .data      (cell_q[i]),
      .hit       (hit[i])
    );
  end

  assign found = |hit;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Operation decode. The duplicate check takes precedence over the full check,
  // so a duplicate push on a full stack still succeeds. The unused mode code
  // fails and leaves the stack unchanged.
  always_comb begin
    ctl                      = '0;
    count_nxt                = count_r;
    out_data_nxt             = '0;
    out_data_nxt.status      = 1'b1;
    if (accept) begin
      unique case (in_data.mode)
        MODE_PUSH: begin
          if (found) begin
            out_data_nxt.status      = 1'b0;
            out_data_nxt.was_present = 1'b1;
          end else if (!full) begin
            ctl.push                 = 1'b1;
            count_nxt                = count_r + CNT_W'(1);
            out_data_nxt.status      = 1'b0;
          end
        end
        MODE_POP: begin
          if (!empty) begin
            ctl.pop                  = 1'b1;
            count_nxt                = count_r - CNT_W'(1);
            out_data_nxt.status      = 1'b0;
          end
        end
        MODE_TOP: begin
          if (!empty) begin
            out_data_nxt.status      = 1'b0;
            out_data_nxt.top_value   = VALUE_W'(cell_q[0]);
          end
        end
        default: begin
          out_data_nxt.status        = 1'b1;
        end
      endcase
    end
    out_data_nxt.is_empty    = (count_nxt == '0);
    out_data_nxt.entry_count = COUNT_W'(count_nxt);
  end

  // Output stage: loads on every accepted transaction, empties when taken.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/dls_checker.sv
`default_nettype none

module dls_checker
  import dls_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled input transaction keeps its valid and its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The input side is only held off by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // The empty flag agrees with the entry count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // A found duplicate is always reported as a success.
  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_present |-> !out_data.status)
    else $error("duplicate push reported as failure");

endmodule

bind dedup_lifo_stack dls_checker u_dls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
